FILE: rtl/ovsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ovsf_pkg;

    // Field widths of the request and result transactions.
    localparam int OP_W   = 2;
    localparam int LVL_W  = 3;
    localparam int IDX_W  = 6;
    localparam int USER_W = 8;
    localparam int STAT_W = 3;
    localparam int CODE_W = 64;
    localparam int CNT_W  = 7;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_ASSIGN   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REL_USER = 2'd2;
    localparam logic [OP_W-1:0] OP_REL_ALL  = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 3'd1;
    localparam logic [STAT_W-1:0] ST_IN_USE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BLOCKED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd4;

    // Saturation limit of a blocker count.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [LVL_W-1:0]  level;
        logic [IDX_W-1:0]  index;
        logic [USER_W-1:0] user_id;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CODE_W-1:0] code_word;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_WALK,
        S_SCAN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_in;
        logic              own_rd_tgt;
        logic              scan_clr;
        logic              scan_inc;
        logic              own_we;
        logic              own_we_scan;
        logic              own_wdata_user;
        logic              walk_start;
        logic              walk_src_scan;
        logic              walk_up;
        logic              clear_all;
        logic              status_we;
        logic [STAT_W-1:0] status;
        logic              out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_ok;
        logic            user_zero;
        logic            owner_zero;
        logic            count_zero;
        logic            owner_match;
        logic            scan_last;
        logic            walk_busy;
        logic            out_free;
        logic            any;
    } t_sts;

    // Walsh code of a node: chip c is the inverted parity of c AND the
    // bit-reversed index, for the low 2^lvl chips; higher chips are zero.
    function automatic logic [CODE_W-1:0] walsh_word(input logic [LVL_W-1:0] lvl,
                                                     input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] w;
        logic [IDX_W-1:0]  rev;
        logic [IDX_W-1:0]  chip;
        w   = '0;
        rev = '0;
        for (int j = 0; j < IDX_W; j++) begin
            if (j < int'(lvl)) begin
                rev[j] = idx[int'(lvl) - 1 - j];
            end
        end
        for (int c = 0; c < CODE_W; c++) begin
            chip = IDX_W'(c);
            if (c < (1 << lvl)) begin
                w[c] = ~^(chip & rev);
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ovsf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ovsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/ovsf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ovsf_ctrl
    import ovsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                case (i_sts.op)
                    OP_ASSIGN: begin
                        n_state = (!i_sts.pos_ok || i_sts.user_zero) ? S_DONE : S_CHECK;
                    end
                    OP_RELEASE: begin
                        n_state = i_sts.pos_ok ? S_CHECK : S_DONE;
                    end
                    OP_REL_USER: begin
                        n_state = i_sts.user_zero ? S_DONE : S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                if (i_sts.op == OP_ASSIGN) begin
                    n_state = (!i_sts.owner_zero || !i_sts.count_zero) ? S_DONE : S_WALK;
                end else begin
                    n_state = i_sts.owner_zero ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (!i_sts.walk_busy) begin
                    if (i_sts.op == OP_REL_USER && !i_sts.scan_last) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.owner_match) begin
                    n_state = S_WALK;
                end else if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_START: begin
                case (i_sts.op)
                    OP_ASSIGN, OP_RELEASE: begin
                        o_cmd.own_rd_tgt = 1'b1;
                        if (!i_sts.pos_ok || (i_sts.op == OP_ASSIGN && i_sts.user_zero)) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_BAD_POS;
                        end
                    end
                    OP_REL_USER: begin
                        o_cmd.scan_clr = 1'b1;
                        if (i_sts.user_zero) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_NOT_USED;
                        end
                    end
                    default: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = ST_OK;
                    end
                endcase
            end
            S_CHECK: begin
                o_cmd.status_we = 1'b1;
                if (i_sts.op == OP_ASSIGN) begin
                    if (!i_sts.owner_zero) begin
                        o_cmd.status = ST_IN_USE;
                    end else if (!i_sts.count_zero) begin
                        o_cmd.status = ST_BLOCKED;
                    end else begin
                        o_cmd.status         = ST_OK;
                        o_cmd.own_we         = 1'b1;
                        o_cmd.own_wdata_user = 1'b1;
                        o_cmd.walk_start     = 1'b1;
                        o_cmd.walk_up        = 1'b1;
                    end
                end else begin
                    if (i_sts.owner_zero) begin
                        o_cmd.status = ST_NOT_USED;
                    end else begin
                        o_cmd.status     = ST_OK;
                        o_cmd.own_we     = 1'b1;
                        o_cmd.walk_start = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (!i_sts.walk_busy && i_sts.op == OP_REL_USER) begin
                    if (!i_sts.scan_last) begin
                        o_cmd.scan_inc = 1'b1;
                    end else begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = i_sts.any ? ST_OK : ST_NOT_USED;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.owner_match) begin
                    o_cmd.own_we        = 1'b1;
                    o_cmd.own_we_scan   = 1'b1;
                    o_cmd.walk_start    = 1'b1;
                    o_cmd.walk_src_scan = 1'b1;
                end else if (i_sts.scan_last) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = i_sts.any ? ST_OK : ST_NOT_USED;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A walk is never left while count updates are still in flight.
    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.walk_busy) |=> (r_state == S_WALK))
        else $error("walk state left while walk busy");

    // Scanning owners only resumes after the previous walk has drained.
    a_scan_idle_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_sts.walk_busy)
        else $error("scan overlaps a walk");

endmodule

`default_nettype wire

FILE: rtl/ovsf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ovsf_dp
    import ovsf_pkg::*;
#(
    parameter int MAX_LEVEL = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int NODES = (1 << (MAX_LEVEL + 1)) - 1;
    localparam int AW    = MAX_LEVEL + 1;
    localparam int NB    = MAX_LEVEL + 2;

    t_in r_in;

    logic          pos_ok;
    logic [NB-1:0] tgt_node;
    logic [AW-1:0] tgt_addr;

    logic [AW-1:0] r_scan_idx;
    logic [AW-1:0] n_scan_idx;
    logic          r_any;

    logic [NODES-1:0] r_own_vld;
    logic [NODES-1:0] r_cnt_vld;
    logic             r_own_rv;
    logic             r_cnt_rv;

    logic [AW-1:0]     own_raddr;
    logic [AW-1:0]     own_waddr;
    logic [USER_W-1:0] own_wdata;
    logic [USER_W-1:0] own_rdata;
    logic [USER_W-1:0] owner_val;

    logic [AW-1:0]    cnt_raddr;
    logic [CNT_W-1:0] cnt_rdata;
    logic [CNT_W-1:0] cnt_val;
    logic [CNT_W-1:0] cnt_wdata;

    logic          r_walk_act;
    logic          r_walk_desc;
    logic          r_walk_up;
    logic [NB-1:0] r_walk_root;
    logic [NB-1:0] r_walk_node;
    logic [NB-1:0] r_row_first;
    logic [NB-1:0] r_row_mask;
    logic          n_walk_act;
    logic          n_walk_desc;
    logic          n_walk_up;
    logic [NB-1:0] n_walk_root;
    logic [NB-1:0] n_walk_node;
    logic [NB-1:0] n_row_first;
    logic [NB-1:0] n_row_mask;
    logic [NB-1:0] start_root;
    logic [NB-1:0] root_sel;
    logic [NB-1:0] anc_next;
    logic [NB-1:0] desc_first;
    logic [NB-1:0] row_next;
    logic          walk_busy;

    logic          r_wb_pend;
    logic [AW-1:0] r_wb_addr;

    logic [STAT_W-1:0] r_status;
    logic              r_out_valid;
    t_out              r_out;
    logic              out_free;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    // Target node number: 2^level + index, root is node 1.
    assign pos_ok   = (r_in.level <= LVL_W'(MAX_LEVEL)) && ((r_in.index >> r_in.level) == '0);
    assign tgt_node = pos_ok ? ((NB'(1) << r_in.level) + NB'(r_in.index)) : NB'(1);
    assign tgt_addr = AW'(tgt_node - NB'(1));

    // Scan index over all store entries.
    always_comb begin
        n_scan_idx = r_scan_idx;
        if (i_cmd.scan_clr) begin
            n_scan_idx = '0;
        end else if (i_cmd.scan_inc) begin
            n_scan_idx = r_scan_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
    end

    // Remembers whether a release by user freed any node.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_clr) begin
            r_any <= 1'b0;
        end else if (i_cmd.own_we && i_cmd.own_we_scan) begin
            r_any <= 1'b1;
        end
    end

    // Owner store.
    assign own_raddr = i_cmd.own_rd_tgt ? tgt_addr : n_scan_idx;
    assign own_waddr = i_cmd.own_we_scan ? r_scan_idx : tgt_addr;
    assign own_wdata = i_cmd.own_wdata_user ? r_in.user_id : '0;

    ovsf_ram #(
        .WIDTH (USER_W),
        .DEPTH (NODES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    // Blocker count store.
    assign cnt_raddr = r_walk_act ? AW'(r_walk_node - NB'(1)) : tgt_addr;

    ovsf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_pend),
        .i_waddr (r_wb_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Valid bits: an entry never written since reset or clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_own_vld <= '0;
            r_cnt_vld <= '0;
        end else begin
            if (i_cmd.own_we) begin
                r_own_vld[own_waddr] <= 1'b1;
            end
            if (r_wb_pend) begin
                r_cnt_vld[r_wb_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_own_rv <= r_own_vld[own_raddr];
        r_cnt_rv <= r_cnt_vld[cnt_raddr];
    end

    assign owner_val = r_own_rv ? own_rdata : '0;
    assign cnt_val   = r_cnt_rv ? cnt_rdata : '0;

    // Relative walk: ancestors up to the root, then descendants row by row.
    assign start_root = i_cmd.walk_src_scan ? (NB'(r_scan_idx) + NB'(1)) : tgt_node;
    assign root_sel   = i_cmd.walk_start ? start_root : r_walk_root;
    assign anc_next   = i_cmd.walk_start ? (start_root >> 1) : (r_walk_node >> 1);
    assign desc_first = root_sel << 1;
    assign row_next   = r_row_first << 1;

    always_comb begin
        n_walk_act  = r_walk_act;
        n_walk_desc = r_walk_desc;
        n_walk_up   = r_walk_up;
        n_walk_root = r_walk_root;
        n_walk_node = r_walk_node;
        n_row_first = r_row_first;
        n_row_mask  = r_row_mask;
        if (i_cmd.walk_start) begin
            n_walk_root = start_root;
            n_walk_up   = i_cmd.walk_up;
        end
        if (i_cmd.walk_start || (r_walk_act && !r_walk_desc)) begin
            if (anc_next != '0) begin
                n_walk_act  = 1'b1;
                n_walk_desc = 1'b0;
                n_walk_node = anc_next;
            end else if (!desc_first[NB-1]) begin
                n_walk_act  = 1'b1;
                n_walk_desc = 1'b1;
                n_walk_node = desc_first;
                n_row_first = desc_first;
                n_row_mask  = NB'(1);
            end else begin
                n_walk_act = 1'b0;
            end
        end else if (r_walk_act) begin
            if ((r_walk_node & r_row_mask) != r_row_mask) begin
                n_walk_node = r_walk_node + NB'(1);
            end else if (row_next[NB-1]) begin
                n_walk_act = 1'b0;
            end else begin
                n_walk_node = row_next;
                n_row_first = row_next;
                n_row_mask  = {r_row_mask[NB-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_act <= 1'b0;
            r_wb_pend  <= 1'b0;
        end else begin
            r_walk_act <= n_walk_act;
            r_wb_pend  <= r_walk_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk_desc <= n_walk_desc;
        r_walk_up   <= n_walk_up;
        r_walk_root <= n_walk_root;
        r_walk_node <= n_walk_node;
        r_row_first <= n_row_first;
        r_row_mask  <= n_row_mask;
        r_wb_addr   <= cnt_raddr;
    end

    assign walk_busy = r_walk_act | r_wb_pend;

    // Saturating count update, written back in the cycle after its read.
    always_comb begin
        if (r_walk_up) begin
            cnt_wdata = (cnt_val == CNT_MAX) ? cnt_val : (cnt_val + CNT_W'(1));
        end else begin
            cnt_wdata = (cnt_val == '0) ? cnt_val : (cnt_val - CNT_W'(1));
        end
    end

    // Result status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
    end

    // Output register, freed when its transaction completes.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status <= r_status;
            if (pos_ok && (r_in.operation == OP_ASSIGN || r_in.operation == OP_RELEASE)) begin
                r_out.code_word <= walsh_word(r_in.level, r_in.index);
            end else begin
                r_out.code_word <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to the controller.
    always_comb begin
        o_sts             = '0;
        o_sts.op          = r_in.operation;
        o_sts.pos_ok      = pos_ok;
        o_sts.user_zero   = (r_in.user_id == '0);
        o_sts.owner_zero  = (owner_val == '0);
        o_sts.count_zero  = (cnt_val == '0);
        o_sts.owner_match = (owner_val == r_in.user_id);
        o_sts.scan_last   = (r_scan_idx == AW'(NODES - 1));
        o_sts.walk_busy   = walk_busy;
        o_sts.out_free    = out_free;
        o_sts.any         = r_any;
    end

    // A count write-back always follows a count read of the walk.
    a_wb_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> $past(r_walk_act))
        else $error("count write without preceding walk read");

    // A new walk never starts on top of a running one.
    a_walk_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_start |-> !walk_busy)
        else $error("walk started while busy");

    // A result is only loaded into a free output register.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result overwrites a pending result");

endmodule

`default_nettype wire

FILE: rtl/ovsf_code_tree_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_in_data  (t_in)
// result    out        o_out_valid / i_out_ready   o_out_data (t_out)
//
// Assign or release of a node updates the count of each ancestor and
// descendant in turn through the read and write ports of the count store;
// a refused request does no walk. Release by user scans every owner entry
// and walks the relatives of each freed node. Reset and release all clear
// both stores at once through per-entry valid bits, so no clearing pass
// follows reset.
// The result register frees the controller while a result waits for i_out_ready.

module ovsf_code_tree_allocator_core
    import ovsf_pkg::*;
#(
    parameter int MAX_LEVEL = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer for requests, walks and scans.
    ovsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Stores, walk address generator and result register.
    ovsf_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ovsf_pkg::*;

    localparam int TREE_DEPTH  = 6;
    localparam int TREE_NODES  = (1 << (TREE_DEPTH + 1)) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Predicted tree state, indexed by node number (root is node 1).
    logic [USER_W-1:0] owner_tab [1:TREE_NODES];
    logic [CNT_W-1:0]  block_tab [1:TREE_NODES];

    t_out        result_q [$];
    t_out        exp_res;
    int          n_errors    = 0;
    int unsigned cycle_count = 0;
    logic        no_idle     = 1'b0;
    logic        hold_tgl    = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;

    ovsf_code_tree_allocator_core #(
        .MAX_LEVEL(TREE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Build the Walsh code by repeated doubling: each step appends either a
    // copy or the complement of the word built so far.
    function automatic logic [CODE_W-1:0] walsh_code(input int lvl, input int idx);
        logic [CODE_W-1:0] w;
        logic [CODE_W-1:0] mask;
        int                len;
        w   = 64'd1;
        len = 1;
        for (int b = lvl; b > 0; b--) begin
            mask = (64'd1 << len) - 64'd1;
            if (((idx >> (b - 1)) & 1) != 0) begin
                w = w | ((~w & mask) << len);
            end else begin
                w = w | (w << len);
            end
            len = len * 2;
        end
        return w;
    endfunction

    // Raise or lower the blocker count of every ancestor and descendant.
    function automatic void mark_family(input int node, input int lvl, input bit up);
        int a;
        int first;
        a = node >> 1;
        while (a > 0) begin
            if (up && block_tab[a] != CNT_MAX) block_tab[a] = block_tab[a] + 1'b1;
            if (!up && block_tab[a] != '0) block_tab[a] = block_tab[a] - 1'b1;
            a = a >> 1;
        end
        for (int d = lvl + 1; d <= TREE_DEPTH; d++) begin
            first = node << (d - lvl);
            for (int j = 0; j < (1 << (d - lvl)); j++) begin
                if (up && block_tab[first + j] != CNT_MAX) begin
                    block_tab[first + j] = block_tab[first + j] + 1'b1;
                end
                if (!up && block_tab[first + j] != '0) begin
                    block_tab[first + j] = block_tab[first + j] - 1'b1;
                end
            end
        end
    endfunction

    function automatic void clear_tree();
        for (int n = 1; n <= TREE_NODES; n++) begin
            owner_tab[n] = '0;
            block_tab[n] = '0;
        end
    endfunction

    // Apply one request to the predicted tree and return the expected result.
    function automatic t_out allocate_result(input t_in req);
        t_out res;
        int   lvl;
        int   idx;
        int   node;
        int   nl;
        bit   any;
        res.status    = ST_OK;
        res.code_word = '0;
        lvl           = int'(req.level);
        idx           = int'(req.index);
        case (req.operation)
            OP_ASSIGN, OP_RELEASE: begin
                if (lvl > TREE_DEPTH || idx >= (1 << lvl)) begin
                    res.status = ST_BAD_POS;
                end else begin
                    node          = (1 << lvl) + idx;
                    res.code_word = walsh_code(lvl, idx);
                    if (req.operation == OP_ASSIGN) begin
                        if (req.user_id == '0) begin
                            res.status = ST_BAD_POS;
                        end else if (owner_tab[node] != '0) begin
                            res.status = ST_IN_USE;
                        end else if (block_tab[node] != '0) begin
                            res.status = ST_BLOCKED;
                        end else begin
                            owner_tab[node] = req.user_id;
                            mark_family(node, lvl, 1'b1);
                        end
                    end else if (owner_tab[node] == '0) begin
                        res.status = ST_NOT_USED;
                    end else begin
                        owner_tab[node] = '0;
                        mark_family(node, lvl, 1'b0);
                    end
                end
            end
            OP_REL_USER: begin
                any = 1'b0;
                if (req.user_id != '0) begin
                    for (int n = 1; n <= TREE_NODES; n++) begin
                        if (owner_tab[n] == req.user_id) begin
                            owner_tab[n] = '0;
                            nl = 0;
                            while ((n >> (nl + 1)) > 0) nl++;
                            mark_family(n, nl, 1'b0);
                            any = 1'b1;
                        end
                    end
                end
                res.status = any ? ST_OK : ST_NOT_USED;
            end
            default: begin
                clear_tree();
            end
        endcase
        return res;
    endfunction

    function automatic t_in make_req(input logic [OP_W-1:0] op, input int lvl, input int idx,
                                     input int user);
        t_in req;
        req.operation = op;
        req.level     = LVL_W'(lvl);
        req.index     = IDX_W'(idx);
        req.user_id   = USER_W'(user);
        return req;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and record the
    // expected result once the transaction is accepted. Entered and left at
    // a rising edge; valid is only lowered by an idle cycle.
    task automatic send_req(input t_in req);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        result_q.insert(result_q.size(), allocate_result(req));
    endtask

    // Receiver side: random stalls, a long hold-off on request, or none.
    always @(posedge i_clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen   <= hold_tgl;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual status %0d code %h",
                         $time, o_out_data.status, o_out_data.code_word);
            end else begin
                exp_res = result_q.pop_front();
                if (o_out_data.status !== exp_res.status) begin
                    n_errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_res.status, o_out_data.status);
                end
                if (o_out_data.code_word !== exp_res.code_word) begin
                    n_errors++;
                    $display("%0t: code_word mismatch, expected %h, actual %h",
                             $time, exp_res.code_word, o_out_data.code_word);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Field extremes, each operation and each corner of the status rules.
    task automatic test_directed();
        send_req(make_req(OP_ASSIGN, 0, 0, 255));
        send_req(make_req(OP_ASSIGN, 1, 0, 1));
        send_req(make_req(OP_ASSIGN, 0, 0, 2));
        send_req(make_req(OP_RELEASE, 0, 0, $urandom_range(0, 255)));
        send_req(make_req(OP_RELEASE, 0, 0, $urandom_range(0, 255)));
        send_req(make_req(OP_ASSIGN, 7, 0, 1));
        send_req(make_req(OP_ASSIGN, 2, 4, 1));
        send_req(make_req(OP_RELEASE, 7, 63, 3));
        send_req(make_req(OP_ASSIGN, 6, 63, 1));
        send_req(make_req(OP_ASSIGN, 3, 5, 0));
        send_req(make_req(OP_ASSIGN, 5, 31, 1));
        send_req(make_req(OP_ASSIGN, 6, 0, 128));
        send_req(make_req(OP_ASSIGN, 4, 7, 1));
        send_req(make_req(OP_REL_USER, 0, 0, 0));
        send_req(make_req(OP_REL_USER, 7, 63, 1));
        send_req(make_req(OP_REL_USER, 0, 0, 1));
        send_req(make_req(OP_ASSIGN, 6, 62, 7));
        send_req(make_req(OP_ASSIGN, 2, 3, 7));
        send_req(make_req(OP_REL_ALL, 7, 63, 255));
        send_req(make_req(OP_REL_USER, 0, 0, 128));
        send_req(make_req(OP_RELEASE, 6, 0, 128));
        send_req(make_req(OP_ASSIGN, 0, 0, 9));
        send_req(make_req(OP_REL_ALL, 0, 0, 0));
        send_req(make_req(OP_ASSIGN, 6, 1, 200));
    endtask

    // Mostly well-formed traffic on a small pool of users so the tree fills
    // and blocks; the rest is raw noise over every bit of the request.
    task automatic test_random_traffic(input int n_items);
        int          r;
        int          lvl;
        int          idx;
        int          user;
        int          node;
        logic [31:0] raw;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                lvl = $urandom_range(0, 2);
            end else if (r < 30) begin
                lvl = $urandom_range(3, 4);
            end else begin
                lvl = $urandom_range(5, 6);
            end
            idx  = $urandom_range(0, (1 << lvl) - 1);
            user = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(0, 255);
            r    = $urandom_range(0, 99);
            if (r < 50) begin
                send_req(make_req(OP_ASSIGN, lvl, idx, user));
            end else if (r < 75) begin
                // Usually pick a node that is held, so releases succeed.
                if ($urandom_range(0, 3) != 0) begin
                    node = $urandom_range(1, TREE_NODES);
                    for (int k = 0; k < TREE_NODES && owner_tab[node] == '0; k++) begin
                        node = (node % TREE_NODES) + 1;
                    end
                    if (owner_tab[node] != '0) begin
                        lvl = 0;
                        while ((node >> (lvl + 1)) > 0) lvl++;
                        idx = node - (1 << lvl);
                    end
                end
                send_req(make_req(OP_RELEASE, lvl, idx, user));
            end else if (r < 83) begin
                send_req(make_req(OP_REL_USER, lvl, idx, user));
            end else if (r < 85) begin
                send_req(make_req(OP_REL_ALL, lvl, idx, user));
            end else begin
                raw = $urandom;
                send_req(raw[18:0]);
            end
        end
    endtask

    // A stretch without idling on either side, then a long receiver hold-off
    // while requests keep coming, so the block fills and stalls its input.
    task automatic test_burst_and_stall();
        no_idle <= 1'b1;
        test_random_traffic(150);
        hold_tgl <= ~hold_tgl;
        test_random_traffic(20);
        no_idle <= 1'b0;
    endtask

    initial begin
        clear_tree();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(450);
        test_burst_and_stall();
        test_random_traffic(380);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
